@@ hdl/gpr_pkg.sv @@
package gpr_pkg;

    // Mono row length in pixels
    localparam int MONO_ROW_WIDTH = 16;

    // Queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    // Step counter of the back sequencer
    localparam int STEP_W = 4;

    // Input command codes
    localparam logic [1:0] CMD_WINDOW = 2'd0;
    localparam logic [1:0] CMD_COVER  = 2'd1;
    localparam logic [1:0] CMD_MONO   = 2'd2;
    localparam logic [1:0] CMD_NONE   = 2'd3;

    // Display controller command codes
    localparam logic [15:0] DC_COLUMN = 16'h002a;
    localparam logic [15:0] DC_ROW    = 16'h002b;
    localparam logic [15:0] DC_WRITE  = 16'h002c;

    // Coverage end points
    localparam logic [7:0] COV_ZERO = 8'h00;
    localparam logic [7:0] COV_FULL = 8'hff;

    // Window sequence steps
    localparam logic [STEP_W-1:0] WIN_COL    = 4'd0;
    localparam logic [STEP_W-1:0] WIN_XS_HI  = 4'd1;
    localparam logic [STEP_W-1:0] WIN_XS_LO  = 4'd2;
    localparam logic [STEP_W-1:0] WIN_XE_HI  = 4'd3;
    localparam logic [STEP_W-1:0] WIN_XE_LO  = 4'd4;
    localparam logic [STEP_W-1:0] WIN_ROW    = 4'd5;
    localparam logic [STEP_W-1:0] WIN_YS_HI  = 4'd6;
    localparam logic [STEP_W-1:0] WIN_YS_LO  = 4'd7;
    localparam logic [STEP_W-1:0] WIN_YE_HI  = 4'd8;
    localparam logic [STEP_W-1:0] WIN_YE_LO  = 4'd9;
    localparam logic [STEP_W-1:0] WIN_WRITE  = 4'd10;
    localparam logic [STEP_W-1:0] STEP_FIRST = 4'd0;
    localparam logic [STEP_W-1:0] MONO_LAST  = STEP_W'(MONO_ROW_WIDTH - 1);
    localparam logic [STEP_W-1:0] ROW_MSB    = 4'd15;

    // Configuration registers
    localparam logic REG_TEXT = 1'b0;
    localparam logic REG_BACK = 1'b1;
    localparam logic [15:0] TEXT_RESET = 16'hffff;
    localparam logic [15:0] BACK_RESET = 16'h0000;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] x_start;
        logic [15:0] x_end;
        logic [15:0] y_start;
        logic [15:0] y_end;
        logic [7:0]  coverage;
        logic [15:0] row_bits;
    } glyph_word_t;

    typedef struct packed {
        logic [15:0] word;
        logic        is_command;
        logic        last;
    } pix_word_t;

    // Queue entry: window packs four coordinates, cover and mono use the low bits
    typedef struct packed {
        logic [1:0]  op;
        logic [63:0] data;
    } q_entry_t;

    typedef struct packed {
        logic           ready;
        logic           head_valid;
        logic [QCW-1:0] count;
    } q_status_t;

endpackage

@@ hdl/gpr_front.sv @@
module gpr_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                glyph_valid,
    output logic                glyph_stall,
    input  gpr_pkg::glyph_word_t glyph_data,
    input  logic                q_ready,
    output logic                push,
    output gpr_pkg::q_entry_t   push_entry
);
    import gpr_pkg::*;

    logic     fr_valid_reg;
    logic     fr_valid_next;
    q_entry_t fr_entry_reg;
    q_entry_t fr_entry_next;
    logic     accept;

    // Hold the input while the word in the front register cannot move on
    assign glyph_stall = fr_valid_reg && !q_ready;
    assign accept      = glyph_valid && !glyph_stall;
    assign push        = fr_valid_reg && q_ready;
    assign push_entry  = fr_entry_reg;

    // Classify the incoming word and pack its payload
    always_comb
    begin
        fr_entry_next    = fr_entry_reg;
        fr_valid_next    = fr_valid_reg && !push;
        if (accept)
        begin
            fr_entry_next.op = glyph_data.cmd;
            unique case (glyph_data.cmd)
                CMD_WINDOW:
                begin
                    fr_entry_next.data = {glyph_data.x_start, glyph_data.x_end,
                                          glyph_data.y_start, glyph_data.y_end};
                    fr_valid_next = 1'b1;
                end
                CMD_COVER:
                begin
                    fr_entry_next.data = {56'd0, glyph_data.coverage};
                    fr_valid_next = 1'b1;
                end
                CMD_MONO:
                begin
                    fr_entry_next.data = {48'd0, glyph_data.row_bits};
                    fr_valid_next = 1'b1;
                end
                default:
                begin
                    // drop the unused command
                    fr_entry_next.data = fr_entry_reg.data;
                    fr_valid_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fr_valid_reg <= 1'b0;
        end
        else
        begin
            fr_valid_reg <= fr_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fr_entry_reg <= fr_entry_next;
    end

endmodule

@@ hdl/gpr_queue.sv @@
module gpr_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  gpr_pkg::q_entry_t   push_entry,
    input  logic                pop,
    output gpr_pkg::q_entry_t   head,
    output gpr_pkg::q_status_t  status
);
    import gpr_pkg::*;

    q_entry_t       mem_reg [QDEPTH];
    logic [QPW-1:0] wr_ptr_reg;
    logic [QPW-1:0] wr_ptr_next;
    logic [QPW-1:0] rd_ptr_reg;
    logic [QPW-1:0] rd_ptr_next;
    logic [QCW-1:0] count_reg;
    logic [QCW-1:0] count_next;
    logic           do_push;
    logic           do_pop;

    assign status.ready      = (count_reg != QCW'(QDEPTH));
    assign status.head_valid = (count_reg != '0);
    assign status.count      = count_reg;
    assign head              = mem_reg[rd_ptr_reg];

    assign do_push = push && status.ready;
    assign do_pop  = pop && status.head_valid;

    // Advance pointers and the fill count
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + QCW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - QCW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed entry
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

@@ hdl/gpr_back.sv @@
module gpr_back (
    input  logic               clk,
    input  logic               rst_n,
    input  gpr_pkg::q_entry_t  head,
    input  logic               head_valid,
    output logic               pop,
    input  logic [15:0]        text_color,
    input  logic [15:0]        back_color,
    output logic               pix_valid,
    input  logic               pix_stall,
    output gpr_pkg::pix_word_t pix_data
);
    import gpr_pkg::*;

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic [STEP_W-1:0] last_step;
    logic              adv;
    logic              issue;
    logic              at_last;

    // Stage one: word selection and blend products
    logic        s1_valid_reg;
    logic [15:0] s1_word_reg,   s1_word_next;
    logic        s1_cmd_reg,    s1_cmd_next;
    logic        s1_last_reg,   s1_last_next;
    logic        s1_blend_reg,  s1_blend_next;
    logic [12:0] s1_rf_reg, s1_rb_reg, s1_bf_reg, s1_bb_reg;
    logic [13:0] s1_gf_reg, s1_gb_reg;
    logic [12:0] rf_next, rb_next, bf_next, bb_next;
    logic [13:0] gf_next, gb_next;

    // Output register
    logic        out_valid_reg;
    pix_word_t   out_data_reg;
    pix_word_t   out_data_next;
    logic [12:0] r_sum;
    logic [12:0] b_sum;
    logic [13:0] g_sum;

    logic [7:0]  alpha;
    logic [7:0]  alpha_inv;
    logic [15:0] mono_row;
    logic        mono_bit;

    assign adv     = !out_valid_reg || !pix_stall;
    assign issue   = head_valid && adv;
    assign at_last = (step_reg == last_step);
    assign pop     = issue && at_last;

    assign alpha     = head.data[7:0];
    assign alpha_inv = ~alpha;
    assign mono_row  = head.data[15:0];
    assign mono_bit  = mono_row[ROW_MSB - step_reg];

    // Pick the final step of the entry at the head
    always_comb
    begin
        unique case (head.op)
            CMD_WINDOW: last_step = WIN_WRITE;
            CMD_MONO:   last_step = MONO_LAST;
            default:    last_step = STEP_FIRST;
        endcase
    end

    // Advance the step counter
    always_comb
    begin
        step_next = step_reg;
        if (issue)
        begin
            step_next = at_last ? STEP_FIRST : step_reg + STEP_W'(1);
        end
    end

    // Multiply each color field by coverage and its complement
    always_comb
    begin
        rf_next = 13'(text_color[15:11]) * 13'(alpha);
        rb_next = 13'(back_color[15:11]) * 13'(alpha_inv);
        gf_next = 14'(text_color[10:5])  * 14'(alpha);
        gb_next = 14'(back_color[10:5])  * 14'(alpha_inv);
        bf_next = 13'(text_color[4:0])   * 13'(alpha);
        bb_next = 13'(back_color[4:0])   * 13'(alpha_inv);
    end

    // Build the word for the current step
    always_comb
    begin
        s1_word_next  = back_color;
        s1_cmd_next   = 1'b0;
        s1_last_next  = at_last;
        s1_blend_next = 1'b0;
        unique case (head.op)
            CMD_WINDOW:
            begin
                case (step_reg)
                    WIN_COL:
                    begin
                        s1_word_next = DC_COLUMN;
                        s1_cmd_next  = 1'b1;
                    end
                    WIN_XS_HI: s1_word_next = {8'd0, head.data[63:56]};
                    WIN_XS_LO: s1_word_next = {8'd0, head.data[55:48]};
                    WIN_XE_HI: s1_word_next = {8'd0, head.data[47:40]};
                    WIN_XE_LO: s1_word_next = {8'd0, head.data[39:32]};
                    WIN_ROW:
                    begin
                        s1_word_next = DC_ROW;
                        s1_cmd_next  = 1'b1;
                    end
                    WIN_YS_HI: s1_word_next = {8'd0, head.data[31:24]};
                    WIN_YS_LO: s1_word_next = {8'd0, head.data[23:16]};
                    WIN_YE_HI: s1_word_next = {8'd0, head.data[15:8]};
                    WIN_YE_LO: s1_word_next = {8'd0, head.data[7:0]};
                    default:
                    begin
                        s1_word_next = DC_WRITE;
                        s1_cmd_next  = 1'b1;
                    end
                endcase
            end
            CMD_COVER:
            begin
                if (alpha == COV_ZERO)
                begin
                    s1_word_next = back_color;
                end
                else if (alpha == COV_FULL)
                begin
                    s1_word_next = text_color;
                end
                else
                begin
                    s1_blend_next = 1'b1;
                end
            end
            CMD_MONO:
            begin
                s1_word_next = mono_bit ? text_color : back_color;
            end
            default:
            begin
                s1_word_next = back_color;
            end
        endcase
    end

    // Sum products and select the output word
    assign r_sum = s1_rf_reg + s1_rb_reg;
    assign g_sum = s1_gf_reg + s1_gb_reg;
    assign b_sum = s1_bf_reg + s1_bb_reg;

    always_comb
    begin
        out_data_next.is_command = s1_cmd_reg;
        out_data_next.last       = s1_last_reg;
        if (s1_blend_reg)
        begin
            out_data_next.word = {r_sum[12:8], g_sum[13:8], b_sum[12:8]};
        end
        else
        begin
            out_data_next.word = s1_word_reg;
        end
    end

    assign pix_valid = out_valid_reg;
    assign pix_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= STEP_FIRST;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            if (adv)
            begin
                s1_valid_reg  <= issue;
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Move payload along when the output can take it
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_word_reg  <= s1_word_next;
            s1_cmd_reg   <= s1_cmd_next;
            s1_last_reg  <= s1_last_next;
            s1_blend_reg <= s1_blend_next;
            s1_rf_reg    <= rf_next;
            s1_rb_reg    <= rb_next;
            s1_gf_reg    <= gf_next;
            s1_gb_reg    <= gb_next;
            s1_bf_reg    <= bf_next;
            s1_bb_reg    <= bb_next;
            out_data_reg <= out_data_next;
        end
    end

endmodule

@@ hdl/glyph_pixel_renderer.sv @@
// Channel   Direction  Handshake                  Word
// glyph     in         glyph_valid / glyph_stall  glyph_word_t: command and its payload
// pix       out        pix_valid / pix_stall      pix_word_t: display bus word and flags
// cfg       in         cfg_we                     cfg_index selects text or back color
//
// One output word per cycle from the back sequencer unless the output stalls: a window
// command gives 11 words, a coverage pixel 1 word, a mono row 16; the unused command none.
// The first word passes the front register, which loads at the accepting edge, then
// the queue, the blend stage and the output register. A 4-entry queue lets
// the front accept while the back is busy.
// Reset clears all valid flags and sets text color to white, back color to black.
// A stalled output freezes the back pipeline; the front keeps filling the queue.
module glyph_pixel_renderer (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 glyph_valid,
    output logic                 glyph_stall,
    input  gpr_pkg::glyph_word_t glyph_data,
    output logic                 pix_valid,
    input  logic                 pix_stall,
    output gpr_pkg::pix_word_t   pix_data,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [15:0]          cfg_data
);
    import gpr_pkg::*;

    logic        text_color_reg;
    logic [15:0] text_reg;
    logic [15:0] back_reg;
    logic        push;
    logic        pop;
    q_entry_t    push_entry;
    q_entry_t    head;
    q_status_t   q_stat;

    // Hold the color registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_reg <= TEXT_RESET;
            back_reg <= BACK_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TEXT: text_reg <= cfg_data;
                default:  back_reg <= cfg_data;
            endcase
        end
    end

    // Flag a pending text color write for the check below
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_color_reg <= 1'b0;
        end
        else
        begin
            text_color_reg <= cfg_we && (cfg_index == REG_TEXT);
        end
    end

    gpr_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .glyph_valid (glyph_valid),
        .glyph_stall (glyph_stall),
        .glyph_data  (glyph_data),
        .q_ready     (q_stat.ready),
        .push        (push),
        .push_entry  (push_entry)
    );

    gpr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .status     (q_stat)
    );

    gpr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (q_stat.head_valid),
        .pop        (pop),
        .text_color (text_reg),
        .back_color (back_reg),
        .pix_valid  (pix_valid),
        .pix_stall  (pix_stall),
        .pix_data   (pix_data)
    );

    // Queue fill never passes its depth
    assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.count <= QCW'(QDEPTH))
        else $error("queue count above depth");

    // Command words carry only the three controller codes
    assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && pix_data.is_command |->
            (pix_data.word == DC_COLUMN) || (pix_data.word == DC_ROW) ||
            (pix_data.word == DC_WRITE))
        else $error("bad command word");

    // The memory write command closes its window sequence
    assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && pix_data.is_command && (pix_data.word == DC_WRITE) |->
            pix_data.last)
        else $error("write command not marked last");

    // A text color write lands in the register on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        text_color_reg |-> (text_reg == $past(cfg_data)))
        else $error("text color write lost");

endmodule
